>>> rtl/ufqd_pkg.sv
// Shared types and constants for the URL form query decoder.
package ufqd_pkg;

  localparam int MAX_RESULTS = 3;
  localparam int CNT_W       = 2;

  localparam logic [7:0] CHR_PLUS    = 8'h2B;
  localparam logic [7:0] CHR_PERCENT = 8'h25;
  localparam logic [7:0] CHR_AMP     = 8'h26;
  localparam logic [7:0] CHR_EQUALS  = 8'h3D;
  localparam logic [7:0] CHR_SPACE   = 8'h20;
  localparam logic [7:0] CHR_NUL     = 8'h00;

  typedef enum logic [1:0] {
    KIND_KEY   = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ESC_NONE  = 2'd0,
    ESC_PCT   = 2'd1,
    ESC_DIGIT = 2'd2
  } esc_t;

  typedef struct packed {
    logic       key_done;
    logic       segment_nonempty;
    esc_t       escape_phase;
    logic [7:0] held_digit;
  } state_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } result_t;

endpackage

>>> rtl/ufqd_decode.sv
// Single-pass decode of one query byte into up to three results and the next state.
module ufqd_decode import ufqd_pkg::*; (
  input  state_t                          state,
  input  logic [7:0]                      char_in,
  input  logic                            end_of_query,
  output state_t                          state_next,
  output result_t [MAX_RESULTS-1:0]       results,
  output logic [CNT_W-1:0]                count
);

  // Valid flag in bit 4, nibble value below.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    return r;
  endfunction

  always_comb begin
    logic                    term;
    logic [4:0]              dig;
    logic [4:0]              hi;
    kind_t                   dkind;
    logic                    do_plain;
    logic                    plain_data;
    logic [7:0]              plain_byte;
    state_t                  st;
    result_t [MAX_RESULTS-1:0] res;
    logic [CNT_W-1:0]        n;

    st         = state;
    res        = '0;
    n          = '0;
    do_plain   = 1'b0;
    plain_data = 1'b0;
    plain_byte = char_in;
    term       = end_of_query || (char_in == CHR_NUL);
    dig        = term ? 5'd0 : hex_val(char_in);
    hi         = hex_val(state.held_digit);
    dkind      = state.key_done ? KIND_VALUE : KIND_KEY;

    // Escape handling first: a broken escape flushes its held bytes as data.
    unique case (state.escape_phase)
      ESC_PCT: begin
        if (dig[4]) begin
          st.held_digit   = char_in;
          st.escape_phase = ESC_DIGIT;
        end else begin
          st.escape_phase = ESC_NONE;
          res[0]          = '{kind: dkind, data: CHR_PERCENT};
          n               = 2'd1;
          do_plain        = 1'b1;
        end
      end
      ESC_DIGIT: begin
        st.escape_phase = ESC_NONE;
        if (dig[4]) begin
          res[0] = '{kind: dkind, data: {(hi[4] ? hi[3:0] : 4'd0), dig[3:0]}};
          n      = 2'd1;
        end else begin
          res[0]   = '{kind: dkind, data: CHR_PERCENT};
          res[1]   = '{kind: dkind, data: state.held_digit};
          n        = 2'd2;
          do_plain = 1'b1;
        end
      end
      default: begin
        st.escape_phase = ESC_NONE;
        do_plain        = 1'b1;
      end
    endcase

    if (n != '0 && !state.key_done) st.segment_nonempty = 1'b1;

    if (do_plain) begin
      priority if (term || char_in == CHR_AMP) begin
        if (st.key_done || st.segment_nonempty) begin
          res[n] = '{kind: KIND_END, data: 8'h00};
          n      = n + 2'd1;
        end
        st.key_done         = 1'b0;
        st.segment_nonempty = 1'b0;
      end else if (char_in == CHR_EQUALS) begin
        if (st.key_done) plain_data = 1'b1;
        else if (st.segment_nonempty) st.key_done = 1'b1;
      end else if (char_in == CHR_PLUS) begin
        plain_data = 1'b1;
        plain_byte = CHR_SPACE;
      end else if (char_in == CHR_PERCENT) begin
        st.escape_phase = ESC_PCT;
      end else begin
        plain_data = 1'b1;
      end
    end

    if (plain_data) begin
      res[n] = '{kind: (st.key_done ? KIND_VALUE : KIND_KEY), data: plain_byte};
      n      = n + 2'd1;
      if (!st.key_done) st.segment_nonempty = 1'b1;
    end

    state_next = st;
    results    = res;
    count      = n;
  end

endmodule

>>> rtl/url_form_query_decoder.sv
// Top level of the URL form query decoder: handshakes, state and result buffer.
// Decodes an application/x-www-form-urlencoded query presented one byte per input
// transfer and returns key bytes, value bytes and end-of-pair markers, one result per
// output transfer, with last_of_run set on the final result of each input byte. '+'
// becomes a space, '%' with two hex digits becomes one byte, and a broken escape is
// passed on literally. A byte of zero or end_of_query closes the query and returns the
// decoder state to its reset values, apart from the held escape digit. Each byte is
// decoded combinationally straight into a three-entry result buffer. The buffer drains
// one result per cycle while out_stall is low; a byte that yields several results (up
// to three) holds the input, and the next byte is taken in the cycle its last result
// leaves, so bytes that yield at most one result sustain one byte per clock without
// output stalls. Bytes that yield no result (the first digit of an escape, a leading
// '=') still take an input transfer of their own. The input is taken in the same
// cycle as the final buffered result leaves, so without output stalls there is no
// bubble between runs; while a result waits on out_stall, the input is stalled with it.
module url_form_query_decoder import ufqd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_in,
  input  logic       end_of_query,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] kind,
  output logic [7:0] data_byte,
  output logic       last_of_run
);

  state_t                    state;
  state_t                    state_next;
  result_t [MAX_RESULTS-1:0] dec_results;
  logic [CNT_W-1:0]          dec_count;

  result_t [MAX_RESULTS-1:0] res_buf;
  logic [CNT_W-1:0]          cnt;
  logic [CNT_W-1:0]          idx;

  logic in_xfer;
  logic out_xfer;
  logic at_last;

  ufqd_decode u_decode (
    .state        (state),
    .char_in      (char_in),
    .end_of_query (end_of_query),
    .state_next   (state_next),
    .results      (dec_results),
    .count        (dec_count)
  );

  // Buffer holds results while cnt is non-zero; idx points at the one on offer.
  assign out_valid   = (cnt != '0);
  assign at_last     = out_valid && ((idx + 2'd1) == cnt);
  assign kind        = res_buf[idx].kind;
  assign data_byte   = res_buf[idx].data;
  assign last_of_run = at_last;

  // Take a new byte when the buffer is empty or its final result leaves now.
  assign in_stall = !(!out_valid || (at_last && !out_stall));
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{key_done: 1'b0, segment_nonempty: 1'b0,
                 escape_phase: ESC_NONE, held_digit: 8'h00};
      cnt   <= '0;
      idx   <= '0;
    end else begin
      // Advance through the buffer; drop the count once the last result goes.
      if (out_xfer) begin
        if (at_last) begin
          cnt <= '0;
          idx <= '0;
        end else begin
          idx <= idx + 2'd1;
        end
      end
      // Load a decoded byte; only happens with the buffer free or freeing.
      if (in_xfer) begin
        state <= state_next;
        cnt   <= dec_count;
        idx   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) res_buf <= dec_results;
  end

  // The offered entry always lies within the loaded run.
  a_idx_in_run: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (idx < cnt))
    else $error("result index beyond loaded run");

  // A new byte must never overwrite results that have not been transferred.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    in_xfer |-> (!out_valid || (at_last && out_xfer)))
    else $error("input taken while results still pending");

  // End-of-pair markers carry a zero byte.
  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_END) |-> (data_byte == 8'h00))
    else $error("end-of-pair marker with non-zero byte");

  // A transfer inside a run moves on to the next buffered result.
  a_run_walks: assert property (@(posedge clk) disable iff (rst)
    (out_xfer && !at_last) |=> (out_valid && idx == $past(idx) + 2'd1))
    else $error("result run did not advance");

endmodule
